>>> hdl/dqr_pkg.sv
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types, constants and byte generators of the DNS query rewriter.
// ----------------------------------------------------------------------------
package dqr_pkg;

  // Query buffer size and derived widths
  localparam int BUFFER_BYTES = 128;
  localparam int POS_W        = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = 16;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_BYTES - 1);
  localparam logic [LEN_W-1:0] BUF_LEN  = LEN_W'(BUFFER_BYTES);

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLVE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_QLEN     = 2'd1;
  localparam logic [7:0]           MAX_QLEN_RESET   = 8'd128;

  // Header byte positions
  localparam logic [3:0] HP_ID_HI = 4'd0;
  localparam logic [3:0] HP_ID_LO = 4'd1;
  localparam logic [3:0] HP_FLAGS = 4'd2;
  localparam logic [3:0] HP_QD_HI = 4'd4;
  localparam logic [3:0] HP_QD_LO = 4'd5;
  localparam logic [3:0] HP_AN_HI = 4'd6;
  localparam logic [3:0] HP_AN_LO = 4'd7;
  localparam logic [3:0] HP_LAST  = 4'd11;
  localparam logic [7:0] FLAGS_RESP = 8'h84;

  // Response sequence index: header 0..11, name end 12, tail 13..16,
  // answer record 17..32
  localparam int KW = 6;
  localparam logic [KW-1:0] K_QNAME = 6'd12;
  localparam logic [KW-1:0] K_ANS   = 6'd17;
  localparam logic [KW-1:0] K_LAST  = 6'd32;
  localparam logic [2:0]    TAIL_BYTES = 3'd4;

  // Command queue
  localparam int Q_DEPTH = 4;
  localparam int QAW     = $clog2(Q_DEPTH);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_QNAME  = 4'b0010,
    PH_TAIL   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // One response step: a real byte, optionally followed by a generated run
  typedef struct packed {
    logic [7:0]    real_byte;
    logic          run;
    logic [KW-1:0] start_k;
    logic [15:0]   qcount;
  } cmd_t;

  // Queue status toward the top level
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] pos, input logic [7:0] b,
                                          input logic [15:0] hold);
    logic [7:0] o;
    case (pos)
      HP_ID_HI, HP_ID_LO, HP_QD_HI, HP_QD_LO: o = b;
      HP_FLAGS: o = FLAGS_RESP | {7'd0, b[0]};
      HP_AN_HI: o = hold[15:8];
      HP_AN_LO: o = hold[7:0];
      default:  o = 8'h00;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] ans_byte(input logic [3:0] off, input logic [31:0] addr);
    logic [7:0] o;
    case (off)
      4'd0:    o = 8'hC0;
      4'd1:    o = 8'h0C;
      4'd3:    o = 8'h01;
      4'd5:    o = 8'h01;
      4'd11:   o = 8'h04;
      4'd12:   o = addr[31:24];
      4'd13:   o = addr[23:16];
      4'd14:   o = addr[15:8];
      4'd15:   o = addr[7:0];
      default: o = 8'h00;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] gen_byte(input logic [KW-1:0] k, input logic [15:0] qc,
                                          input logic [31:0] addr);
    logic [KW-1:0] off;
    logic [7:0]    o;
    off = k - K_ANS;
    if (k < K_QNAME) begin
      o = hdr_byte(k[3:0], 8'h00, qc);
    end else if (k < K_ANS) begin
      o = 8'h00;
    end else begin
      o = ans_byte(off[3:0], addr);
    end
    return o;
  endfunction

endpackage

>>> hdl/dqr_if.sv
// ----------------------------------------------------------------------------
// dqr_if
// Valid/ready channel interfaces: query bytes, response bytes, register writes.
// ----------------------------------------------------------------------------
interface dqr_in_if;
  import dqr_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] packet_length;
  modport source (output valid, data_byte, packet_length, input ready);
  modport sink   (input valid, data_byte, packet_length, output ready);
endinterface

interface dqr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;
  modport source (output valid, out_byte, last_out, input ready);
  modport sink   (input valid, out_byte, last_out, output ready);
endinterface

interface dqr_cfg_if;
  import dqr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> hdl/dqr_front.sv
// ----------------------------------------------------------------------------
// dqr_front
// Parses query bytes, applies the length check and header rewrite, and
// issues one command per accepted byte of a kept packet, up to its last tail byte.
// ----------------------------------------------------------------------------
module dqr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  dqr_in_if.sink                in_ch,
  input  logic [7:0]            max_qlen,
  input  logic                  q_full,
  output logic                  cmd_push,
  output dqr_pkg::cmd_t         cmd
);
  import dqr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  phase_t           phase_r, phase_nxt;
  logic [15:0]      hold_r, hold_nxt;
  logic [2:0]       tail_r, tail_nxt;
  logic             drop_r, drop_nxt;

  logic             accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Classify the current byte and build its command
  always_comb begin
    logic             first;
    logic [LEN_W-1:0] len, eff, rem_cur, rem_dec;
    logic [POS_W-1:0] pos_cur;
    phase_t           ph_cur, ph_new;
    logic [15:0]      hold_cur, hold_new;
    logic [2:0]       tail_cur, tail_new;
    logic             drop_cur, tail_fin, end_pkt;
    logic [7:0]       b;

    first    = (rem_r == '0);
    len      = (in_ch.packet_length == '0) ? LEN_W'(1) : in_ch.packet_length;
    eff      = (len > BUF_LEN) ? BUF_LEN : len;
    drop_cur = first ? (eff > {{(LEN_W-8){1'b0}}, max_qlen}) : drop_r;
    rem_cur  = first ? len : rem_r;
    rem_dec  = rem_cur - LEN_W'(1);
    end_pkt  = (rem_dec == '0);
    pos_cur  = first ? '0 : pos_r;
    ph_cur   = first ? PH_HEADER : phase_r;
    hold_cur = first ? 16'h0000 : hold_r;
    tail_cur = first ? 3'd0 : tail_r;
    b        = (pos_cur == POS_LAST) ? 8'h00 : in_ch.data_byte;

    ph_new   = ph_cur;
    hold_new = hold_cur;
    tail_new = tail_cur;
    tail_fin = 1'b0;
    cmd      = '0;

    case (ph_cur)
      PH_HEADER: begin
        cmd.real_byte = hdr_byte(pos_cur[3:0], b, hold_cur);
        if (pos_cur[3:0] == HP_QD_HI) hold_new[15:8] = b;
        if (pos_cur[3:0] == HP_QD_LO) hold_new[7:0]  = b;
        if (pos_cur >= POS_W'(HP_LAST)) ph_new = PH_QNAME;
      end
      PH_QNAME: begin
        cmd.real_byte = b;
        if (b == 8'h00) begin
          ph_new   = PH_TAIL;
          tail_new = TAIL_BYTES;
        end
      end
      PH_TAIL: begin
        cmd.real_byte = b;
        if (tail_cur != 3'd0) tail_new = tail_cur - 3'd1;
        if (tail_new == 3'd0) begin
          tail_fin = 1'b1;
          ph_new   = PH_DONE;
        end
      end
      default: begin
        cmd.real_byte = 8'h00;
      end
    endcase

    // Append the answer, or complete a short packet with generated bytes and the answer
    cmd.qcount = hold_new;
    if (tail_fin) begin
      cmd.run     = 1'b1;
      cmd.start_k = K_ANS;
    end else if (end_pkt) begin
      case (ph_new)
        PH_HEADER: begin
          cmd.run     = 1'b1;
          cmd.start_k = {{(KW-4){1'b0}}, pos_cur[3:0]} + KW'(1);
        end
        PH_QNAME: begin
          cmd.run     = 1'b1;
          cmd.start_k = K_QNAME;
        end
        PH_TAIL: begin
          cmd.run     = 1'b1;
          cmd.start_k = K_ANS - {{(KW-3){1'b0}}, tail_new};
        end
        default: begin
          cmd.run = 1'b0;
        end
      endcase
    end

    cmd_push = accept && !drop_cur && (ph_cur != PH_DONE);

    // Advance the parse state; rewind at end of packet
    if (end_pkt) begin
      pos_nxt   = '0;
      rem_nxt   = '0;
      phase_nxt = PH_HEADER;
      tail_nxt  = 3'd0;
    end else begin
      pos_nxt   = (pos_cur == POS_LAST) ? pos_cur : pos_cur + POS_W'(1);
      rem_nxt   = rem_dec;
      phase_nxt = ph_new;
      tail_nxt  = tail_new;
    end
    hold_nxt = hold_new;
    drop_nxt = drop_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      rem_r   <= '0;
      phase_r <= PH_HEADER;
      hold_r  <= 16'h0000;
      tail_r  <= 3'd0;
      drop_r  <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      tail_r  <= tail_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

>>> hdl/dqr_fifo.sv
// ----------------------------------------------------------------------------
// dqr_fifo
// Short command queue between the parser and the response generator.
// ----------------------------------------------------------------------------
module dqr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dqr_pkg::cmd_t     wr_cmd,
  input  logic              pop,
  output dqr_pkg::cmd_t     rd_cmd,
  output dqr_pkg::q_stat_t  stat
);
  import dqr_pkg::*;

  cmd_t           mem_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign rd_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (QAW+1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (QAW+1)'(1);
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/dqr_back.sv
// ----------------------------------------------------------------------------
// dqr_back
// Expands queued commands into response bytes and drives the output register.
// ----------------------------------------------------------------------------
module dqr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dqr_pkg::cmd_t     q_cmd,
  input  dqr_pkg::q_stat_t  q_stat,
  output logic              q_pop,
  input  logic [31:0]       resolve_addr,
  dqr_out_if.source         out_ch
);
  import dqr_pkg::*;

  logic          busy_r, busy_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    real_r;
  logic          run_r;
  logic [KW-1:0] k_r, k_nxt;
  logic [15:0]   qc_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          slot, emit, fin;
  logic [7:0]    cur_byte;
  logic          cur_last;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last_out = out_last_r;

  // Pick the next byte of the current command
  assign slot     = !out_valid_r || out_ch.ready;
  assign emit     = busy_r && slot;
  assign cur_byte = pend_r ? real_r : gen_byte(k_r, qc_r, resolve_addr);
  assign cur_last = !pend_r && (k_r == K_LAST);
  assign fin      = pend_r ? !run_r : (k_r == K_LAST);
  assign q_pop    = q_stat.valid && (!busy_r || (emit && fin));

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    k_nxt    = k_r;
    if (emit) begin
      if (pend_r) pend_nxt = 1'b0;
      else        k_nxt    = k_r + KW'(1);
      if (fin)    busy_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b1;
      k_nxt    = q_cmd.start_k;
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load command payload and output register
  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (q_pop) begin
      real_r <= q_cmd.real_byte;
      run_r  <= q_cmd.run;
      qc_r   <= q_cmd.qcount;
    end
    if (emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= cur_last;
    end
  end

endmodule

>>> hdl/dns_query_to_fixed_answer_rewriter_unit.sv
// ----------------------------------------------------------------------------
// dns_query_to_fixed_answer_rewriter_unit
// Rewrites a streamed DNS query into a response carrying a fixed A record.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one query byte per transfer together with the packet
// length, which is sampled on the first byte of each packet. out_ch gives one
// response byte per transfer; last_out marks the final byte (the last address
// octet). cfg_ch writes register 0 (answer address) or 1 (maximum query
// length); other indexes are ignored. cfg_ch is always ready.
// Throughput: one query byte per cycle. A kept query expands to 16 more
// bytes for the answer record, and a short packet expands on its last byte
// to at most 33 response bytes; the response generator emits one byte per
// cycle while out_ch is ready, so the input stalls once the four-entry
// command queue fills. Dropped (oversized) packets and bytes after the
// answer produce nothing. Each command is registered in the queue and in
// the generator's command registers; its bytes leave via the output register.
// Reset: rst_n, synchronous, clears the parser, the queue and the output
// register and sets address 0 and maximum length 128. When out_ch stalls the
// output byte holds, the queue fills, and then in_ch.ready drops.
// ----------------------------------------------------------------------------
module dns_query_to_fixed_answer_rewriter_unit (
  input  logic      clk,
  input  logic      rst_n,
  dqr_in_if.sink    in_ch,
  dqr_out_if.source out_ch,
  dqr_cfg_if.sink   cfg_ch
);
  import dqr_pkg::*;

  logic [31:0] addr_r;
  logic [7:0]  max_qlen_r;

  logic        cmd_push;
  cmd_t        cmd_in, cmd_head;
  q_stat_t     q_stat;
  logic        q_pop;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= 32'h0000_0000;
      max_qlen_r <= MAX_QLEN_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_RESOLVE_ADDR: addr_r     <= cfg_ch.wdata;
        REG_MAX_QLEN:     max_qlen_r <= cfg_ch.wdata[7:0];
        default: ;
      endcase
    end
  end

  dqr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .max_qlen (max_qlen_r),
    .q_full   (q_stat.full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  dqr_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd_in),
    .pop    (q_pop),
    .rd_cmd (cmd_head),
    .stat   (q_stat)
  );

  dqr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_cmd        (cmd_head),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .resolve_addr (addr_r),
    .out_ch       (out_ch)
  );

  // Output is empty right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // A full queue must stall the input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_ch.ready)
    else $error("input ready while command queue full");

  // A queue entry not taken stays queued
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.valid && !q_pop) |=> q_stat.valid)
    else $error("command queue lost an entry");

  // The final response byte is the last address octet
  a_last_octet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_out) |-> (out_ch.out_byte == addr_r[7:0]))
    else $error("final byte differs from address octet");

endmodule

>>> dv/dqr_resp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dqr_resp_checker
// Rebuilds the expected response stream from the query bytes and register
// writes seen on the channels and compares it with every response transfer.
// ----------------------------------------------------------------------------
module dqr_resp_checker (
  input  logic clk,
  input  logic rst_n,
  dqr_in_if    in_ch,
  dqr_out_if   out_ch,
  dqr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import dqr_pkg::*;

  // Fixed part of the A record: name pointer, type A, class IN, TTL 0, length 4
  localparam logic [95:0] A_RECORD_HEAD  = 96'hC00C_0001_0001_0000_0000_0004;
  localparam int          A_RECORD_BYTES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } resp_byte_t;

  resp_byte_t  resp_expected[$];
  logic [31:0] answer_addr;
  logic [7:0]  max_qlen;
  logic [15:0] pos;
  logic [15:0] remain;
  logic [15:0] qd_hold;
  phase_t      phase;
  logic [2:0]  tail_left;
  logic        dropping;
  int          errors     = 0;
  int          resp_index = 0;

  assign fail_count = errors;

  function automatic void emit(input logic [7:0] data, input logic last);
    resp_expected.push_back(resp_byte_t'{data, last});
  endfunction

  function automatic void emit_answer();
    logic [127:0] rec;
    rec = {A_RECORD_HEAD, answer_addr};
    for (int i = 0; i < A_RECORD_BYTES; i++)
      emit(rec[127 - 8*i -: 8], i == A_RECORD_BYTES - 1);
  endfunction

  // Rewrite one query byte (real or zero fill) at the current position
  function automatic void rewrite_query_byte(input logic [7:0] b);
    logic [7:0] hdr;
    case (phase)
      PH_HEADER: begin
        case (pos)
          HP_ID_HI, HP_ID_LO: hdr = b;
          HP_FLAGS: hdr = FLAGS_RESP | {7'd0, b[0]};
          HP_QD_HI: begin
            hdr           = b;
            qd_hold[15:8] = b;
          end
          HP_QD_LO: begin
            hdr          = b;
            qd_hold[7:0] = b;
          end
          HP_AN_HI: hdr = qd_hold[15:8];
          HP_AN_LO: hdr = qd_hold[7:0];
          default:  hdr = 8'h00;
        endcase
        emit(hdr, 1'b0);
        if (pos >= 16'(HP_LAST)) phase = PH_QNAME;
      end
      PH_QNAME: begin
        emit(b, 1'b0);
        if (b == 8'h00) begin
          phase     = PH_TAIL;
          tail_left = TAIL_BYTES;
        end
      end
      PH_TAIL: begin
        emit(b, 1'b0);
        if (tail_left > 0) tail_left--;
        if (tail_left == 0) begin
          emit_answer();
          phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the packet state by one transferred query byte
  function automatic void take_query_byte(input logic [7:0] data, input logic [15:0] plen);
    logic [15:0] len;
    logic [15:0] eff;
    logic [7:0]  b;
    b = data;
    if (pos == 16'd0) begin
      len       = (plen == 16'd0) ? 16'd1 : plen;
      eff       = (len < BUF_LEN) ? len : BUF_LEN;
      remain    = len;
      dropping  = eff > {8'd0, max_qlen};
      phase     = PH_HEADER;
      qd_hold   = '0;
      tail_left = '0;
    end
    if (pos >= BUF_LEN - 16'd1) b = 8'h00;
    if (!dropping) rewrite_query_byte(b);
    pos++;
    if (remain > 0) remain--;
    if (remain == 0) begin
      // finish a short packet with zero bytes
      if (!dropping) begin
        while (phase != PH_DONE) begin
          rewrite_query_byte(8'h00);
          pos++;
        end
      end
      pos       = '0;
      phase     = PH_HEADER;
      tail_left = '0;
    end
  endfunction

  function automatic void check_response();
    resp_byte_t want;
    if (resp_expected.size() == 0) begin
      $display("%0t: response byte %0d arrived with none expected: out_byte %02h last_out %0b",
               $time, resp_index, out_ch.out_byte, out_ch.last_out);
      errors++;
    end else begin
      want = resp_expected.pop_front();
      if (out_ch.out_byte !== want.data) begin
        $display("%0t: response byte %0d out_byte: expected %02h, actual %02h",
                 $time, resp_index, want.data, out_ch.out_byte);
        errors++;
      end
      if (out_ch.last_out !== want.last) begin
        $display("%0t: response byte %0d last_out: expected %0b, actual %0b",
                 $time, resp_index, want.last, out_ch.last_out);
        errors++;
      end
    end
    resp_index++;
  endfunction

  // Track register writes, predict on query transfers, check response transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      resp_expected.delete();
      answer_addr = '0;
      max_qlen    = MAX_QLEN_RESET;
      pos         = '0;
      remain      = '0;
      qd_hold     = '0;
      phase       = PH_HEADER;
      tail_left   = '0;
      dropping    = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_RESOLVE_ADDR: answer_addr = cfg_ch.wdata;
          REG_MAX_QLEN:     max_qlen    = cfg_ch.wdata[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) take_query_byte(in_ch.data_byte, in_ch.packet_length);
      if (out_ch.valid && out_ch.ready) check_response();
    end
    pending <= resp_expected.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives DNS queries and register writes into the rewriter: a directed set
// of edge packets, then random queries over several register settings with
// random idling on both channels, one long response stall and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
  import dqr_pkg::*;

  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int LIMIT_NS       = 20_000_000;
  localparam int IDLE_PCT       = 30;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES  = 12;
  localparam int ITEM_TARGET    = 310;
  localparam int RANDOM_PHASES  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic       clk;
  logic       rst_n;
  int         fail_count;
  int         pending;
  bit         calm         = 1'b0;
  bit         rx_hold_req  = 1'b0;
  int         sent_bytes   = 0;

  dqr_in_if  in_ch ();
  dqr_out_if out_ch ();
  dqr_cfg_if cfg_ch ();

  dns_query_to_fixed_answer_rewriter_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dqr_resp_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("dns_query_to_fixed_answer_rewriter_unit verification failed");
    $finish;
  end

  // Response side: random ready, a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one query byte, with random idle cycles ahead of it
  task automatic put_byte(input logic [7:0] data, input logic [15:0] plen);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= data;
    in_ch.packet_length <= plen;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  // Send a whole packet; bytes past the given ones are random
  task automatic send_packet(input logic [7:0] q[$], input logic [15:0] len);
    int n;
    n = (len == 16'd0) ? 1 : int'(len);
    sent_bytes += n;
    for (int i = 0; i < n; i++)
      put_byte((i < q.size()) ? q[i] : 8'($urandom), (i == 0) ? len : 16'($urandom));
  endtask

  // Drop valid and hold until every expected response has been transferred
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random query: mostly well formed, some truncated, some noise
  task automatic make_query(ref logic [7:0] q[$], output logic [15:0] len);
    int kind;
    int n;
    q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 40);
      repeat (n) q.push_back(8'($urandom));
      len = 16'(n);
      if ($urandom_range(4) == 0) len = 16'd0;
    end else begin
      repeat (12) q.push_back(8'($urandom));
      repeat ($urandom_range(0, 3)) begin
        n = $urandom_range(1, 12);
        q.push_back(8'(n));
        repeat (n) q.push_back(8'($urandom_range(1, 255)));
      end
      q.push_back(8'h00);
      repeat (4) q.push_back(8'($urandom));
      repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
      len = 16'(q.size());
      if (kind < 30) len = 16'($urandom_range(1, q.size() - 1));
    end
  endtask

  initial begin
    logic [7:0]  q[$];
    logic [15:0] len;
    int          base;
    int          budget;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.packet_length <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= '0;
    cfg_ch.wdata        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a zero length counts as one byte, then a one-byte packet
    q = {8'hFF};
    send_packet(q, 16'd0);
    q = {8'h00};
    send_packet(q, 16'd1);
    settle();

    write_reg(REG_RESOLVE_ADDR, 32'hFFFF_FFFF);
    write_reg(REG_MAX_QLEN, 32'd128);
    // Full query with every header bit set, two bytes after the question;
    // hold off the receiver so the queue fills and the input stalls
    q = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
         8'h03, 8'h77, 8'h77, 8'h77, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'hAA, 8'h55};
    rx_hold_req = 1'b1;
    send_packet(q, 16'(q.size()));
    // Same question with every header bit clear but the question count
    for (int i = 0; i < 12; i++) q[i] = 8'h00;
    q[HP_QD_HI] = 8'h12;
    q[HP_QD_LO] = 8'h34;
    send_packet(q, 16'(q.size()));
    // Packet ends halfway through type and class, then inside the header
    send_packet(q, 16'(q.size() - 4));
    send_packet(q, 16'd5);
    // Name never terminates: last buffer byte ends it, tail lies past the buffer;
    // no idling on either side for the whole packet
    q.delete();
    repeat (BUFFER_BYTES + 1) q.push_back(8'hFF);
    calm = 1'b1;
    send_packet(q, 16'(q.size()));
    calm = 1'b0;
    settle();

    // Smallest limit: a bare header is kept, anything longer dropped
    write_reg(REG_RESOLVE_ADDR, 32'h0000_0000);
    write_reg(REG_MAX_QLEN, 32'd12);
    q.delete();
    repeat (12) q.push_back(8'($urandom));
    send_packet(q, 16'd12);
    send_packet(q, 16'd13);
    settle();

    // Writes to unused indexes change nothing
    write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_3, 32'h0000_0000);
    send_packet(q, 16'd12);
    send_packet(q, 16'd13);

    // Random queries over several settings, up to the item budget
    base   = sent_bytes;
    budget = (ITEM_TARGET > base) ? ITEM_TARGET - base : 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      write_reg(REG_RESOLVE_ADDR, $urandom);
      write_reg(REG_MAX_QLEN, (ph % 3 == 0) ? 32'd128 : 32'($urandom_range(24, 128)));
      while (sent_bytes < base + (ph + 1) * budget / RANDOM_PHASES) begin
        make_query(q, len);
        send_packet(q, len);
        if ($urandom_range(19) == 0) settle();
      end
    end
    settle();

    if (fail_count == 0) begin
      $display("dns_query_to_fixed_answer_rewriter_unit verification clean");
    end else begin
      $display("dns_query_to_fixed_answer_rewriter_unit verification failed");
    end
    $finish;
  end

endmodule
